### rtl/rgbc3_pkg.sv
// Shared types and constants for the 3x3 RGB convolution block.
`default_nettype none

package rgbc3_pkg;

    localparam int MAX_WIDTH_DEF      = 1024;
    localparam int COEF_FRAC_BITS_DEF = 8;

    localparam int PIX_W     = 8;
    localparam int WORD_W    = 3 * PIX_W;
    localparam int COEF_W    = 16;
    localparam int ROW_CFG_W = 3 * COEF_W;
    localparam int PROD_W    = PIX_W + 1 + COEF_W;
    localparam int RSUM_W    = PROD_W + 2;
    localparam int SUM_W     = RSUM_W + 2;

    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 48;

    localparam logic [ROW_CFG_W-1:0] COEF_TOP_RST    = 48'h0;
    localparam logic [ROW_CFG_W-1:0] COEF_MIDDLE_RST = 48'h0000_0100_0000;
    localparam logic [ROW_CFG_W-1:0] COEF_BOTTOM_RST = 48'h0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH     = 3'd0,
        CFG_IMAGE_HEIGHT    = 3'd1,
        CFG_COEF_TOP_ROW    = 3'd2,
        CFG_COEF_MIDDLE_ROW = 3'd3,
        CFG_COEF_BOTTOM_ROW = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic             last_result;
    } pix_out_t;

endpackage

`default_nettype wire

### rtl/rgb_conv3x3_zero_pad.sv
// Top level of the streaming 3x3 RGB convolution with zero padding.
`default_nettype none

// Streaming 3x3 convolution on RGB pixels in raster order, one word per clock when both
// sides keep up. The two previous rows live in one line memory (older and newer row side
// by side) with a registered read; each word reads its column on acceptance and writes
// it back once it leaves stage a, with forwarding when a row is one pixel wide. A masked
// window copy, the products, the row sums and the clamped total follow in four more
// registered stages. Results lag the stream by one row plus one pixel; send
// image_width+1 flush words after the frame. Configuration is to be written only
// while the block is idle; the block itself does not enforce this.
module rgb_conv3x3_zero_pad
    import rgbc3_pkg::*;
#(
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pix_in_t              in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pix_out_t                  out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = IMG_H_W + 1;

    typedef logic [2:0][2:0][WORD_W-1:0] win_t;

    // Configuration.
    logic [IMG_W_W-1:0]   img_w_reg;
    logic [IMG_H_W-1:0]   img_h_reg;
    logic [ROW_CFG_W-1:0] coef_reg [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg   <= IMG_W_W'(MAX_WIDTH_DEF);
            img_h_reg   <= IMG_H_W'(1);
            coef_reg[0] <= COEF_TOP_RST;
            coef_reg[1] <= COEF_MIDDLE_RST;
            coef_reg[2] <= COEF_BOTTOM_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:     img_w_reg   <= cfg_data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT:    img_h_reg   <= cfg_data[IMG_H_W-1:0];
                CFG_COEF_TOP_ROW:    coef_reg[0] <= cfg_data[ROW_CFG_W-1:0];
                CFG_COEF_MIDDLE_ROW: coef_reg[1] <= cfg_data[ROW_CFG_W-1:0];
                CFG_COEF_BOTTOM_ROW: coef_reg[2] <= cfg_data[ROW_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    logic [WW-1:0] eff_w;
    logic [RW-1:0] eff_h;

    always_comb
    begin
        if (img_w_reg == '0)
            eff_w = WW'(1);
        else if (32'(img_w_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(img_w_reg);
        eff_h = (img_h_reg == '0) ? RW'(1) : {1'b0, img_h_reg};
    end

    // Stream position counters, advanced as each word is accepted.
    logic [CW-1:0]      in_col_reg, in_col_next;
    logic [RW-1:0]      in_row_reg, in_row_next;
    logic [CW-1:0]      out_col_reg, out_col_next;
    logic [IMG_H_W-1:0] out_row_reg, out_row_next;

    logic          in_fire;
    logic          emit;
    logic          last;
    logic [2:0]    row_ok, col_ok;
    logic [8:0]    mask;
    logic [WW-1:0] icol_w, ocol_w;
    logic [RW-1:0] orow_w;

    always_comb
    begin
        icol_w = WW'(in_col_reg);
        ocol_w = WW'(out_col_reg);
        orow_w = {1'b0, out_row_reg};
        emit   = (in_row_reg >= RW'(2)) || (in_row_reg == RW'(1) && in_col_reg != '0);

        row_ok[0] = (orow_w != '0) && (orow_w - RW'(1) < eff_h);
        row_ok[1] = orow_w < eff_h;
        row_ok[2] = orow_w + RW'(1) < eff_h;
        col_ok[0] = (ocol_w != '0) && (ocol_w - WW'(1) < eff_w);
        col_ok[1] = ocol_w < eff_w;
        col_ok[2] = ocol_w + WW'(1) < eff_w;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mask[r*3+c] = row_ok[r] & col_ok[c];
            end
        end

        last = emit && (ocol_w + WW'(1) >= eff_w) && (orow_w + RW'(1) >= eff_h);

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (in_fire)
        begin
            if (icol_w + WW'(1) >= eff_w)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (emit)
            begin
                if (ocol_w + WW'(1) >= eff_w)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + IMG_H_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
            if (last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Line memory: older row in the upper half, newer row in the lower half.
    logic [2*WORD_W-1:0] line_mem [MAX_WIDTH];
    logic [2*WORD_W-1:0] mem_q;
    logic [2*WORD_W-1:0] wr_data;
    logic [2*WORD_W-1:0] rd_data;

    // Stage a: word whose memory read is in flight.
    logic              a_valid_reg;
    logic [CW-1:0]     a_col_reg;
    logic [WORD_W-1:0] a_pix_reg;
    logic              a_emit_reg;
    logic [8:0]        a_mask_reg;
    logic              a_last_reg;
    logic              fwd_reg;
    logic [2*WORD_W-1:0] fwd_data_reg;
    logic              a_fire;

    // Stage b: masked window copy; stage c: products; stage d: row sums.
    logic                              b_valid_reg, c_valid_reg, d_valid_reg;
    logic                              b_last_reg, c_last_reg, d_last_reg;
    logic                              b_ready, c_ready, d_ready, o_ready;
    win_t                              b_win_reg;
    logic signed [PROD_W-1:0]          c_prod_reg [3][3][3];
    logic signed [RSUM_W-1:0]          d_row_reg [3][3];
    logic                              out_valid_reg;
    pix_out_t                          out_data_reg;

    win_t win_reg, win_new;

    assign o_ready  = !out_valid_reg || out_ready;
    assign d_ready  = !d_valid_reg || o_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_fire   = a_valid_reg && (!a_emit_reg || b_ready);
    assign in_ready = !a_valid_reg || a_fire;
    assign in_fire  = in_valid && in_ready;

    assign rd_data = fwd_reg ? fwd_data_reg : mem_q;
    assign wr_data = {rd_data[WORD_W-1:0], a_pix_reg};

    always_ff @(posedge clk)
    begin
        if (a_fire)
            line_mem[a_col_reg] <= wr_data;
        if (in_fire)
            mem_q <= line_mem[in_col_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                a_valid_reg <= 1'b1;
                // A one-pixel row reads the entry being written in the same cycle.
                fwd_reg     <= a_fire && (a_col_reg == in_col_reg);
            end
            else if (a_fire)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_col_reg    <= in_col_reg;
            a_pix_reg    <= in_data.action ? '0
                                           : {in_data.blue, in_data.green, in_data.red};
            a_emit_reg   <= emit;
            a_mask_reg   <= mask;
            a_last_reg   <= last;
            fwd_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_new[r][0] = win_reg[r][1];
            win_new[r][1] = win_reg[r][2];
        end
        win_new[0][2] = rd_data[2*WORD_W-1:WORD_W];
        win_new[1][2] = rd_data[WORD_W-1:0];
        win_new[2][2] = a_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (a_fire)
            win_reg <= win_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
                b_valid_reg <= a_fire && a_emit_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
            if (d_ready)
                d_valid_reg <= c_valid_reg;
            if (o_ready)
                out_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_fire)
        begin
            b_last_reg <= a_last_reg;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    b_win_reg[r][c] <= a_mask_reg[r*3+c] ? win_new[r][c] : '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_last_reg <= b_last_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        c_prod_reg[ch][r][c] <=
                            $signed({1'b0, b_win_reg[r][c][ch*PIX_W +: PIX_W]}) *
                            $signed(coef_reg[r][c*COEF_W +: COEF_W]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && c_valid_reg)
        begin
            d_last_reg <= c_last_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    d_row_reg[ch][r] <= RSUM_W'(c_prod_reg[ch][r][0])
                                      + RSUM_W'(c_prod_reg[ch][r][1])
                                      + RSUM_W'(c_prod_reg[ch][r][2]);
                end
            end
        end
    end

    function automatic logic [PIX_W-1:0] clamp_sum(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] q;
        q = s >>> COEF_FRAC_BITS;
        if (s < 0)
            return '0;
        else if (q > SUM_W'(255))
            return PIX_W'(255);
        else
            return q[PIX_W-1:0];
    endfunction

    logic signed [SUM_W-1:0] tot [3];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            tot[ch] = SUM_W'(d_row_reg[ch][0]) + SUM_W'(d_row_reg[ch][1])
                    + SUM_W'(d_row_reg[ch][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && d_valid_reg)
        begin
            out_data_reg.out_red     <= clamp_sum(tot[0]);
            out_data_reg.out_green   <= clamp_sum(tot[1]);
            out_data_reg.out_blue    <= clamp_sum(tot[2]);
            out_data_reg.last_result <= d_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
